// File: hdl/ppp_pkg.sv
// Shared constants, widths and register codes for the pinhole point projector.
// No dependencies; imported by ppp_div and pinhole_point_projection.
`timescale 1ns / 1ps

package ppp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QCAP_BITS = 41;

  // Camera-frame coordinates carry 27 + FRAC_BITS fraction bits in 64 bits.
  localparam int PC_W   = 64;
  localparam int NUM_W  = PC_W + 32 + FRAC_BITS;
  localparam int DEN_W  = PC_W + 32;
  localparam int CMP_W  = DEN_W + QCAP_BITS + 1;
  localparam int QOUT_W = QCAP_BITS + 1;
  localparam int RES_W  = QOUT_W + 2;

  // Divider depth: one range check stage plus one stage per quotient bit.
  localparam int DIV_LAT = QCAP_BITS + 1;

  localparam int ADDR_W = 5;

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(64'sh7fffffff);
  localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-64'sh80000000);

  localparam logic [2:0] REG_FOCAL_X      = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y      = 3'd1;
  localparam logic [2:0] REG_PITCH_X      = 3'd2;
  localparam logic [2:0] REG_PITCH_Y      = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

endpackage

// File: hdl/pinhole_point_projection.sv
// Pinhole point projector: turns each accepted input beat into one result beat.
// Throughput is one beat per cycle while the output buffer has room; the long pole is the bit-per-stage divider.
// The whole pipe advances together and holds only while the two-entry output buffer is full.
// Reset (rst, synchronous) empties the pipe and output buffer and loads the
// register defaults: focal 1.0, pitch 1.0, image 640 x 480.
`timescale 1ns / 1ps

module pinhole_point_projection import ppp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z, point_x, point_y, point_z
  input  logic [255:0]      s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // pixel_u, pixel_v
  output logic [63:0]       m_tdata,
  // behind_camera, saturated
  output logic [1:0]        m_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic [31:0] focal_x, focal_y, pitch_x, pitch_y;
  logic [15:0] image_width, image_height;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= 32'd65536;
      focal_y      <= 32'd65536;
      pitch_x      <= 32'd65536;
      pitch_y      <= 32'd65536;
      image_width  <= 16'd640;
      image_height <= 16'd480;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FOCAL_X:      focal_x      <= pwdata;
        REG_FOCAL_Y:      focal_y      <= pwdata;
        REG_PITCH_X:      pitch_x      <= pwdata;
        REG_PITCH_Y:      pitch_y      <= pwdata;
        REG_IMAGE_WIDTH:  image_width  <= pwdata[15:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FOCAL_X:      prdata = focal_x;
      REG_FOCAL_Y:      prdata = focal_y;
      REG_PITCH_X:      prdata = pitch_x;
      REG_PITCH_Y:      prdata = pitch_y;
      REG_IMAGE_WIDTH:  prdata = {16'd0, image_width};
      REG_IMAGE_HEIGHT: prdata = {16'd0, image_height};
      default:          prdata = '0;
    endcase
  end

  // Pipeline control
  logic en;
  logic skid_valid;
  logic v1, v2, v3, v4, v5, v6, v7;
  logic [DIV_LAT-1:0] vsh, bsh;

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5  <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
      vsh <= '0;
    end else if (en) begin
      v1  <= s_tvalid;
      v2  <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
      vsh <= {vsh[DIV_LAT-2:0], v7};
    end
  end

  // Stage 1: quaternion products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] xx1, yy1, zz1, xy1, wz1, xz1, wy1, yz1, wx1;
  logic signed [31:0] t1 [0:2];
  logic signed [31:0] p1 [0:2];

  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      xx1 <= qx * qx; yy1 <= qy * qy; zz1 <= qz * qz;
      xy1 <= qx * qy; wz1 <= qw * qz; xz1 <= qx * qz;
      wy1 <= qw * qy; yz1 <= qy * qz; wx1 <= qw * qx;
      for (int i = 0; i < 3; i++) begin
        t1[i] <= s_tdata[64 + 32*i +: 32];
        p1[i] <= s_tdata[160 + 32*i +: 32];
      end
    end
  end

  // Stage 2: rotation entries already halved (Q29); the halving is exact.
  localparam logic signed [32:0] HALF_ONE = 33'sd536870912;
  logic signed [32:0] rh2 [0:8];
  logic signed [31:0] t2 [0:2];
  logic signed [31:0] p2 [0:2];

  function automatic logic signed [32:0] sx33(input logic signed [31:0] a);
    return {a[31], a};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      rh2[0] <= HALF_ONE - (sx33(yy1) + sx33(zz1));
      rh2[1] <= sx33(xy1) - sx33(wz1);
      rh2[2] <= sx33(xz1) + sx33(wy1);
      rh2[3] <= sx33(xy1) + sx33(wz1);
      rh2[4] <= HALF_ONE - (sx33(xx1) + sx33(zz1));
      rh2[5] <= sx33(yz1) - sx33(wx1);
      rh2[6] <= sx33(xz1) - sx33(wy1);
      rh2[7] <= sx33(yz1) + sx33(wx1);
      rh2[8] <= HALF_ONE - (sx33(xx1) + sx33(yy1));
      t2 <= t1;
      p2 <= p1;
    end
  end

  // Stage 3: nine rotation products
  logic signed [64:0] pr3 [0:8];
  logic signed [31:0] t3 [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        pr3[i] <= rh2[i] * p2[i % 3];
      end
      t3 <= t2;
    end
  end

  // Stage 4: floor each product by two bits, sum rows and add the translation.
  logic signed [PC_W-1:0] pc4 [0:2];

  function automatic logic signed [PC_W-1:0] fl2(input logic signed [64:0] a);
    return {a[64], a[64:2]};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pc4[i] <= fl2(pr3[3*i]) + fl2(pr3[3*i+1]) + fl2(pr3[3*i+2])
                  + {{5{t3[i][31]}}, t3[i], 27'd0};
      end
    end
  end

  // Stage 5: depth test and magnitudes
  logic            beh5, negx5, negy5;
  logic [PC_W-1:0] magx5, magy5, dep5;

  always_ff @(posedge clk) begin
    if (en) begin
      beh5  <= (pc4[2] <= 0);
      negx5 <= pc4[0][PC_W-1];
      negy5 <= pc4[1][PC_W-1];
      magx5 <= pc4[0][PC_W-1] ? -pc4[0] : pc4[0];
      magy5 <= pc4[1][PC_W-1] ? -pc4[1] : pc4[1];
      dep5  <= pc4[2];
    end
  end

  // Stage 6: 32x32 partial products of numerator and denominator
  logic [31:0] pex, pey;
  logic [63:0] nxl6, nxh6, nyl6, nyh6, dxl6, dxh6, dyl6, dyh6;
  logic        beh6, negx6, negy6;

  assign pex = (pitch_x == '0) ? 32'd1 : pitch_x;
  assign pey = (pitch_y == '0) ? 32'd1 : pitch_y;

  always_ff @(posedge clk) begin
    if (en) begin
      nxl6  <= 64'(magx5[31:0]) * 64'(focal_x);
      nxh6  <= 64'(magx5[63:32]) * 64'(focal_x);
      nyl6  <= 64'(magy5[31:0]) * 64'(focal_y);
      nyh6  <= 64'(magy5[63:32]) * 64'(focal_y);
      dxl6  <= 64'(dep5[31:0]) * 64'(pex);
      dxh6  <= 64'(dep5[63:32]) * 64'(pex);
      dyl6  <= 64'(dep5[31:0]) * 64'(pey);
      dyh6  <= 64'(dep5[63:32]) * 64'(pey);
      beh6  <= beh5;
      negx6 <= negx5;
      negy6 <= negy5;
    end
  end

  // Stage 7: combine partial products into divider operands
  logic [NUM_W-1:0] numx7, numy7;
  logic [DEN_W-1:0] denx7, deny7;
  logic             beh7, negx7, negy7;

  always_ff @(posedge clk) begin
    if (en) begin
      numx7 <= (NUM_W'(nxh6) << (32 + FRAC_BITS)) + (NUM_W'(nxl6) << FRAC_BITS);
      numy7 <= (NUM_W'(nyh6) << (32 + FRAC_BITS)) + (NUM_W'(nyl6) << FRAC_BITS);
      denx7 <= (DEN_W'(dxh6) << 32) + DEN_W'(dxl6);
      deny7 <= (DEN_W'(dyh6) << 32) + DEN_W'(dyl6);
      beh7  <= beh6;
      negx7 <= negx6;
      negy7 <= negy6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bsh <= {bsh[DIV_LAT-2:0], beh7};
    end
  end

  logic              negx_d, negy_d;
  logic [QOUT_W-1:0] qx_d, qy_d;

  ppp_div u_div_x (
    .clk     (clk),
    .en      (en),
    .neg_in  (negx7),
    .num     (numx7),
    .den     (denx7),
    .neg_out (negx_d),
    .quot    (qx_d)
  );

  ppp_div u_div_y (
    .clk     (clk),
    .en      (en),
    .neg_in  (negy7),
    .num     (numy7),
    .den     (deny7),
    .neg_out (negy_d),
    .quot    (qy_d)
  );

  // Final: apply sign, add image center, clamp.
  function automatic logic [32:0] finish(input logic neg, input logic [QOUT_W-1:0] q,
                                         input logic [15:0] size);
    logic signed [RES_W-1:0] s;
    logic signed [RES_W-1:0] c;
    logic signed [RES_W-1:0] r;
    s = neg ? -$signed(RES_W'(q)) : $signed(RES_W'(q));
    c = $signed(RES_W'({size[15:1], {FRAC_BITS{1'b0}}}));
    r = s + c;
    if (r > SAT_HI) return {1'b1, SAT_HI[31:0]};
    if (r < SAT_LO) return {1'b1, SAT_LO[31:0]};
    return {1'b0, r[31:0]};
  endfunction

  logic [32:0] fu, fv;
  logic        vz, bz;
  logic [31:0] new_u, new_v;
  logic        new_b, new_s;

  assign vz = vsh[DIV_LAT-1];
  assign bz = bsh[DIV_LAT-1];
  assign fu = finish(negx_d, qx_d, image_width);
  assign fv = finish(negy_d, qy_d, image_height);

  always_comb begin
    if (bz) begin
      new_u = '0; new_v = '0; new_b = 1'b1; new_s = 1'b0;
    end else begin
      new_u = fu[31:0]; new_v = fv[31:0]; new_b = 1'b0; new_s = fu[32] | fv[32];
    end
  end

  // Output register with one skid entry.
  logic [31:0] out_u, out_v, skid_u, skid_v;
  logic        out_b, out_s, skid_b, skid_s;
  logic        pop, push;

  assign pop  = m_tvalid && m_tready;
  assign push = en && vz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_u <= skid_u; out_v <= skid_v; out_b <= skid_b; out_s <= skid_s;
        skid_valid <= 1'b0;
      end
    end else if (m_tvalid) begin
      if (pop && push) begin
        out_u <= new_u; out_v <= new_v; out_b <= new_b; out_s <= new_s;
      end else if (pop) begin
        m_tvalid <= 1'b0;
      end else if (push) begin
        skid_u <= new_u; skid_v <= new_v; skid_b <= new_b; skid_s <= new_s;
        skid_valid <= 1'b1;
      end
    end else if (push) begin
      out_u <= new_u; out_v <= new_v; out_b <= new_b; out_s <= new_s;
      m_tvalid <= 1'b1;
    end
  end

  assign m_tdata = {out_v, out_u};
  assign m_tuser = {out_s, out_b};

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid entry held without output beat");

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
    else $error("behind-camera beat carries nonzero pixel data");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1) else $error("accepted beat did not enter pipe");
`endif

endmodule

// File: hdl/ppp_div.sv
// Pipelined restoring divider: one quotient bit per stage, quotient capped at 2^41.
// Depends on ppp_pkg for widths.
`timescale 1ns / 1ps

module ppp_div import ppp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic              neg_in,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              neg_out,
  output logic [QOUT_W-1:0] quot
);

  logic [NUM_W-1:0]     rem [0:QCAP_BITS];
  logic [DEN_W-1:0]     dv  [0:QCAP_BITS];
  logic [QCAP_BITS-1:0] qv  [0:QCAP_BITS];
  logic                 big [0:QCAP_BITS];
  logic                 ng  [0:QCAP_BITS];

  // A quotient of 2^41 or more is flagged here and replaced by the cap at the end.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      qv[0]  <= '0;
      ng[0]  <= neg_in;
      big[0] <= CMP_W'(num) >= (CMP_W'(den) << QCAP_BITS);
    end
  end

  for (genvar k = 1; k <= QCAP_BITS; k++) begin : g_stage
    localparam int B = QCAP_BITS - k;
    logic [CMP_W-1:0] shifted;
    logic [CMP_W-1:0] diff;
    logic             ge;

    always_comb begin
      shifted = CMP_W'(dv[k-1]) << B;
      ge      = CMP_W'(rem[k-1]) >= shifted;
      diff    = CMP_W'(rem[k-1]) - shifted;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[NUM_W-1:0] : rem[k-1];
        dv[k]  <= dv[k-1];
        qv[k]  <= qv[k-1] | (QCAP_BITS'(ge) << B);
        big[k] <= big[k-1];
        ng[k]  <= ng[k-1];
      end
    end
  end

  assign quot    = big[QCAP_BITS] ? (QOUT_W'(1) << QCAP_BITS) : {1'b0, qv[QCAP_BITS]};
  assign neg_out = ng[QCAP_BITS];

endmodule
